@@ rtl/core/m4vt_pkg.sv @@
// Shared types and constants for the 4x4 matrix / 4-vector transform unit.
// Holds the beat structs, the item kind codes and the default number format.
// No dependencies.
package m4vt_pkg;

    localparam int FIELD_W       = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DIM           = 4;
    localparam int IDX_W         = 4;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_XFORM = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    entry_index;
        logic [FIELD_W-1:0]  entry_value;
        logic [FIELD_W-1:0]  vec_x;
        logic [FIELD_W-1:0]  vec_y;
        logic [FIELD_W-1:0]  vec_z;
        logic [FIELD_W-1:0]  vec_w;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0]  out_x;
        logic [FIELD_W-1:0]  out_y;
        logic [FIELD_W-1:0]  out_z;
        logic [FIELD_W-1:0]  out_w;
        logic                saturated;
    } t_out_beat;

    // Control that travels with a beat down the cell chain.
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
    } t_ctl;

endpackage

@@ rtl/core/m4vt_cell.sv @@
// One column cell of the transform chain: holds one matrix column, multiplies
// it by its vector component and adds into the row sums. Depends on m4vt_pkg.
module m4vt_cell import m4vt_pkg::*; #(
    parameter int DW  = DATA_WIDTH_DEF,
    parameter int COL = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  t_ctl                        i_ctl,
    input  logic [DW-1:0]               i_value,
    input  logic [DIM-1:0][DW-1:0]      i_vec,
    input  logic [DIM-1:0][2*DW+1:0]    i_acc,
    output t_ctl                        o_ctl,
    output logic [DW-1:0]               o_value,
    output logic [DIM-1:0][DW-1:0]      o_vec,
    output logic [DIM-1:0][2*DW+1:0]    o_acc
);

    localparam int AW = 2*DW + 2;
    localparam int PW = 2*DW;

    logic [DIM-1:0][DW-1:0]  r_col;
    t_ctl                    r_a_ctl;
    logic [DW-1:0]           r_a_value;
    logic [DIM-1:0][DW-1:0]  r_a_vec;
    logic [DIM-1:0][AW-1:0]  r_a_acc;
    logic [DIM-1:0][PW-1:0]  r_a_prod;
    t_ctl                    r_b_ctl;
    logic [DW-1:0]           r_b_value;
    logic [DIM-1:0][DW-1:0]  r_b_vec;
    logic [DIM-1:0][AW-1:0]  r_b_acc;

    logic [DIM-1:0][PW-1:0]  n_prod;
    logic [DIM-1:0][AW-1:0]  n_acc;
    logic                    w_load_here;

    assign w_load_here = i_ctl.valid && (i_ctl.kind == KIND_LOAD)
                         && (i_ctl.idx[IDX_W-1:2] == 2'(COL));

    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            n_prod[r] = $signed(r_col[r]) * $signed(i_vec[COL]);
            n_acc[r]  = r_a_acc[r] + AW'($signed(r_a_prod[r]));
        end
    end

    // Column storage: a load writes here as it passes, so it stays in order
    // with the transforms ahead of and behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_adv && w_load_here) begin
            r_col[i_ctl.idx[1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_adv) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_value <= i_value;
            r_a_vec   <= i_vec;
            r_a_acc   <= i_acc;
            r_a_prod  <= n_prod;
            r_b_value <= r_a_value;
            r_b_vec   <= r_a_vec;
            r_b_acc   <= n_acc;
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_value = r_b_value;
    assign o_vec   = r_b_vec;
    assign o_acc   = r_b_acc;

endmodule

@@ rtl/core/m4vt_round.sv @@
// Rounds one accumulated row sum to the output format and saturates it.
// Depends on m4vt_pkg.
module m4vt_round import m4vt_pkg::*; #(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic [2*DW+1:0]     i_acc,
    output logic [FIELD_W-1:0]  o_res,
    output logic                o_sat
);

    localparam int AW = 2*DW + 2;

    logic [AW-1:0]      w_sum;
    logic [AW-1:0]      w_shift;
    logic [AW-DW:0]     w_top;
    logic [DW-1:0]      w_val;

    // Round to nearest, ties up, then drop the fraction bits.
    assign w_sum   = i_acc + (AW'(1) << (FB - 1));
    assign w_shift = AW'($signed(w_sum) >>> FB);
    assign w_top   = w_shift[AW-1:DW-1];
    assign o_sat   = !((&w_top) || (~|w_top));

    always_comb begin
        if (o_sat) begin
            w_val = w_top[AW-DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            w_val = w_shift[DW-1:0];
        end
    end

    generate
        if (DW >= FIELD_W) begin : g_cut
            assign o_res = w_val[FIELD_W-1:0];
        end else begin : g_ext
            assign o_res = {{(FIELD_W-DW){w_val[DW-1]}}, w_val};
        end
    endgenerate

endmodule

@@ rtl/core/mat4_vec4_transform_unit.sv @@
// Top level of the 4x4 matrix times 4-vector transform unit.
// Depends on m4vt_pkg, m4vt_cell and m4vt_round.
//
// The unit holds a 4x4 signed fixed-point matrix (column-major, entry
// 4*column+row, all zero after reset) and multiplies it by one vector per
// beat. It takes one beat every cycle while o_in_stall is low and returns
// each transform result through four column cells of two stages each
// (multiply, then accumulate), one rounding stage and the output register.
// A load beat writes one entry and gives no result; it travels the same
// chain and updates its column as it passes that column's cell, so loads
// and transforms take effect strictly in arrival order and may be freely
// interleaved. Each result component is the exact sum of four products,
// rounded to nearest (ties toward plus infinity) and saturated to the
// DATA_WIDTH range; saturated flags any clipped component. A skid register
// behind the output register lets the chain keep taking beats while a
// result waits; o_in_stall rises only when both are full.
module mat4_vec4_transform_unit import m4vt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_beat,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_beat  o_out_beat
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = 2*DW + 2;

    // Chain links: link 0 feeds cell 0, link DIM leaves the last cell.
    t_ctl                    w_ctl   [0:DIM];
    logic [DW-1:0]           w_value [0:DIM];
    logic [DIM-1:0][DW-1:0]  w_vec   [0:DIM];
    logic [DIM-1:0][AW-1:0]  w_acc   [0:DIM];

    logic                    w_adv;
    logic                    w_take;
    logic                    w_push;
    logic [DIM-1:0][FIELD_W-1:0] w_res;
    logic [DIM-1:0]          w_sat;
    logic [DIM-1:0][FIELD_W-1:0] w_field;

    logic                    r_fin_valid;
    t_out_beat               r_fin;
    logic                    r_out_valid;
    t_out_beat               r_out;
    logic                    r_skid_valid;
    t_out_beat               r_skid;
    t_out_beat               n_fin;

    // The whole chain moves together; hold it only while the skid is full.
    assign w_adv      = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    assign w_field = {i_in_beat.vec_w, i_in_beat.vec_z, i_in_beat.vec_y, i_in_beat.vec_x};

    // Operands are the low DATA_WIDTH bits of each field, or the whole field sign-extended when DATA_WIDTH is wider.
    generate
        if (DW <= FIELD_W) begin : g_in_cut
            assign w_value[0] = i_in_beat.entry_value[DW-1:0];
            for (genvar c = 0; c < DIM; c++) begin : g_vec
                assign w_vec[0][c] = w_field[c][DW-1:0];
            end
        end else begin : g_in_ext
            assign w_value[0] = {{(DW-FIELD_W){i_in_beat.entry_value[FIELD_W-1]}},
                                 i_in_beat.entry_value};
            for (genvar c = 0; c < DIM; c++) begin : g_vec
                assign w_vec[0][c] = {{(DW-FIELD_W){w_field[c][FIELD_W-1]}}, w_field[c]};
            end
        end
    endgenerate

    assign w_ctl[0].valid = i_in_valid;
    assign w_ctl[0].kind  = i_in_beat.kind;
    assign w_ctl[0].idx   = i_in_beat.entry_index;
    assign w_acc[0]       = '0;

    // One cell per matrix column; row sums advance one cell every two stages.
    generate
        for (genvar c = 0; c < DIM; c++) begin : g_cell
            m4vt_cell #(
                .DW  (DW),
                .COL (c)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_ctl   (w_ctl[c]),
                .i_value (w_value[c]),
                .i_vec   (w_vec[c]),
                .i_acc   (w_acc[c]),
                .o_ctl   (w_ctl[c+1]),
                .o_value (w_value[c+1]),
                .o_vec   (w_vec[c+1]),
                .o_acc   (w_acc[c+1])
            );
        end

        for (genvar r = 0; r < DIM; r++) begin : g_round
            m4vt_round #(
                .DW (DW),
                .FB (FRAC_BITS)
            ) u_round (
                .i_acc (w_acc[DIM][r]),
                .o_res (w_res[r]),
                .o_sat (w_sat[r])
            );
        end
    endgenerate

    always_comb begin
        n_fin.out_x     = w_res[0];
        n_fin.out_y     = w_res[1];
        n_fin.out_z     = w_res[2];
        n_fin.out_w     = w_res[3];
        n_fin.saturated = |w_sat;
    end

    // Rounding stage: only transform beats carry on; load beats drop here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_adv) begin
            r_fin_valid <= w_ctl[DIM].valid && (w_ctl[DIM].kind == KIND_XFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin <= n_fin;
        end
    end

    // Output register plus skid: a finished result leaves the rounding stage
    // whenever the chain advances, into the output register if it is free
    // or being taken, else into the skid.
    assign w_take = r_out_valid && !i_out_stall;
    assign w_push = r_fin_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= r_fin;
            end
        end else if (w_push) begin
            r_skid <= r_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

@@ test/tb.sv @@
// Self-checking bench for mat4_vec4_transform_unit: directed table, then random beats.
// Holds a bit-accurate matrix-times-vector predictor with rounding and saturation.
// Depends on m4vt_pkg and the RTL of the unit.
module tb;
    import m4vt_pkg::*;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_HALF = 32'h0000_8000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ALL1 = 32'hFFFF_FFFF;

    localparam int RANDOM_BEATS   = 1500;
    localparam int CALM_BEATS     = 200;
    localparam int HOLD_AT        = 400;
    localparam int PAUSE_AT       = 900;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    // Exact dot products need 66 bits; keep some headroom.
    localparam logic signed [69:0] SUM_MAX    = 70'sd2147483647;
    localparam logic signed [69:0] SUM_MIN    = -70'sd2147483648;
    localparam logic signed [69:0] ROUND_HALF = 70'sd1 <<< (FRAC_BITS_DEF - 1);

    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        t_out_beat result;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;

    // Hand-typed result that rides along with the beat on offer.
    bit        row_fixed  = 1'b0;
    t_out_beat row_result = '0;

    // Receiver control.
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    bit calm        = 1'b0;
    bit burst_stall = 1'b0;
    int hold_left   = 0;
    int burst_left  = 0;

    logic signed [31:0] matrix_copy [16] = '{default: '0};
    t_out_beat          pending_results [$];
    t_stim_row          directed_rows [$];
    int                 fail_count   = 0;
    int                 quiet_cycles = 0;

    mat4_vec4_transform_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Row r of the product: exact sum over columns, round half up, clip to 32 bits.
    function automatic t_out_beat transform_vector(input t_in_beat b);
        logic signed [31:0] vec [4];
        logic [31:0]        comp [4];
        logic signed [69:0] acc;
        t_out_beat          res;
        vec[0] = b.vec_x;
        vec[1] = b.vec_y;
        vec[2] = b.vec_z;
        vec[3] = b.vec_w;
        res = '0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + matrix_copy[4 * c + r] * vec[c];
            end
            acc = (acc + ROUND_HALF) >>> FRAC_BITS_DEF;
            if (acc > SUM_MAX) begin
                comp[r] = Q_MAX;
                res.saturated = 1'b1;
            end else if (acc < SUM_MIN) begin
                comp[r] = Q_MIN;
                res.saturated = 1'b1;
            end else begin
                comp[r] = acc[31:0];
            end
        end
        res.out_x = comp[0];
        res.out_y = comp[1];
        res.out_z = comp[2];
        res.out_w = comp[3];
        return res;
    endfunction

    // Mix of extremes, tiny values for rounding, full-range noise and values within plus or minus four.
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'($urandom_range(0, 128)) - 32'd64;
            3, 4: return $urandom();
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic t_stim_row stim_row(input t_kind k, input logic [3:0] idx,
                                           input logic [31:0] val, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z,
                                           input logic [31:0] w, input bit fixed,
                                           input t_out_beat result);
        t_stim_row row;
        row.beat.kind        = k;
        row.beat.entry_index = idx;
        row.beat.entry_value = val;
        row.beat.vec_x       = x;
        row.beat.vec_y       = y;
        row.beat.vec_z       = z;
        row.beat.vec_w       = w;
        row.fixed            = fixed;
        row.result           = result;
        return row;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Present one beat and hold it until taken; valid stays high on return.
    task automatic offer(input t_in_beat b, input bit fixed, input t_out_beat result);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        row_fixed  <= fixed;
        row_result <= result;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_for(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Track accepted beats: loads update the matrix copy, transforms queue a result.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (i_in_beat.kind == KIND_LOAD) begin
                    matrix_copy[i_in_beat.entry_index] = i_in_beat.entry_value;
                end else begin
                    pending_results.push_back(row_fixed ? row_result
                                                        : transform_vector(i_in_beat));
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: %h", o_out_beat);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_x", want.out_x, o_out_beat.out_x);
                    check_field("out_y", want.out_y, o_out_beat.out_y);
                    check_field("out_z", want.out_z, o_out_beat.out_z);
                    check_field("out_w", want.out_w, o_out_beat.out_w);
                    check_field("saturated", {31'b0, want.saturated},
                                {31'b0, o_out_beat.saturated});
                end
            end
        end
    end

    // Output stall: random bursts, one long hold on request, none once calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left  <= burst_left - 1;
            i_out_stall <= burst_stall;
        end else begin
            burst_left  <= $urandom_range(1, 16);
            burst_stall <= !calm && ($urandom_range(0, 2) == 0);
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        t_in_beat b;
        // Zero matrix after reset gives zero whatever the vector.
        directed_rows.push_back(stim_row(KIND_XFORM, 4'hF, Q_MAX, Q_MAX, Q_MIN, Q_ONE, Q_ALL1,
                                         1'b1, '0));
        // Load identity; vector fields of a load carry junk.
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd0, Q_ONE, Q_ALL1, Q_MAX, Q_MIN, Q_ONE,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd5, Q_ONE, Q_MAX, Q_ALL1, Q_ONE, Q_MIN,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd10, Q_ONE, Q_MIN, Q_ONE, Q_ALL1, Q_MAX,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd15, Q_ONE, Q_ONE, Q_MIN, Q_MAX, Q_ALL1,
                                         1'b0, '0));
        // Identity passes the vector through, extremes included.
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h7, Q_MIN, Q_ONE, 32'h0002_0000,
                                         32'hFFFD_0000, Q_MAX, 1'b1,
                                         {Q_ONE, 32'h0002_0000, 32'hFFFD_0000, Q_MAX, 1'b0}));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, Q_ALL1, Q_MIN, Q_MAX, 32'h0, Q_ALL1,
                                         1'b1, {Q_MIN, Q_MAX, 32'h0, Q_ALL1, 1'b0}));
        // Huge off-diagonal entries in row 0: clip high, then clip low.
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd4, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd8, Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'h0, Q_MAX, Q_MAX, 32'h0,
                                         1'b1, {Q_MAX, Q_MAX, Q_MAX, 32'h0, 1'b1}));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'h0, Q_MIN, Q_MIN, 32'h0,
                                         1'b1, {Q_MIN, Q_MIN, Q_MIN, 32'h0, 1'b1}));
        // Half in entry 0: ties round toward plus infinity.
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd0, Q_HALF, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd4, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd8, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'd1, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, Q_ALL1, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'd3, Q_ALL1, 32'h0, 32'h0,
                                         1'b0, '0));
        // Most negative times itself clips high in row 3.
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd15, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, Q_MIN,
                                         1'b1, {32'h0, 32'h0, 32'h0, Q_MAX, 1'b1}));
        directed_rows.push_back(stim_row(KIND_LOAD, 4'd3, Q_MIN, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, Q_MAX, 32'h0, 32'h0, Q_MAX,
                                         1'b0, '0));
        directed_rows.push_back(stim_row(KIND_XFORM, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                         1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            offer(directed_rows[k].beat, directed_rows[k].fixed, directed_rows[k].result);
            if ($urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 16));
            end
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Drop all idling for the tail of the run.
            if (n == RANDOM_BEATS - CALM_BEATS) begin
                calm <= 1'b1;
            end
            // Ask for one long output hold; keep offering so the chain backs up.
            if (n == HOLD_AT) begin
                hold_req <= 1'b1;
            end
            // Pause the sender until every pending result has drained.
            if (n == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            b.kind        = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_XFORM;
            b.entry_index = 4'($urandom_range(0, 15));
            b.entry_value = rand_q16();
            b.vec_x       = rand_q16();
            b.vec_y       = rand_q16();
            b.vec_z       = rand_q16();
            b.vec_w       = rand_q16();
            offer(b, 1'b0, '0);
            if (n < RANDOM_BEATS - CALM_BEATS && $urandom_range(0, 5) == 0) begin
                idle_for($urandom_range(1, 16));
            end
        end

        // Drain, then linger past the pipeline depth to catch stray beats.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ mat4_vec4_transform_unit.f @@
rtl/core/m4vt_pkg.sv
rtl/core/m4vt_cell.sv
rtl/core/m4vt_round.sv
rtl/core/mat4_vec4_transform_unit.sv
test/tb.sv
